>>> hdl/tfn_pkg.sv
// tfn_pkg: shared types and constants for the triangle face normal block.
// Used by tfn_unit3 and triangle_face_normal; no dependencies.
package tfn_pkg;

    // Vertex coordinates, signed Q16.16
    localparam int COORD_WIDTH = 32;
    // Threshold register, unsigned Q1.30
    localparam int CFG_WIDTH   = 31;
    // Unit vector components, signed Q1.30
    localparam int UNIT_WIDTH  = 32;
    localparam int FRAC_BITS   = 30;

    localparam logic [CFG_WIDTH-1:0] MIN_CROSS_RESET = 31'd1073742;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] a_x;
        logic signed [COORD_WIDTH-1:0] a_y;
        logic signed [COORD_WIDTH-1:0] a_z;
        logic signed [COORD_WIDTH-1:0] b_x;
        logic signed [COORD_WIDTH-1:0] b_y;
        logic signed [COORD_WIDTH-1:0] b_z;
        logic signed [COORD_WIDTH-1:0] c_x;
        logic signed [COORD_WIDTH-1:0] c_y;
        logic signed [COORD_WIDTH-1:0] c_z;
    } tfn_in_t;

    typedef struct packed {
        logic signed [UNIT_WIDTH-1:0] normal_x;
        logic signed [UNIT_WIDTH-1:0] normal_y;
        logic signed [UNIT_WIDTH-1:0] normal_z;
        logic                         used_alternate;
        logic                         degenerate;
    } tfn_out_t;

endpackage

>>> hdl/tfn_unit3.sv
// tfn_unit3: pipelined unit vector of a signed 3-vector, Q1.30 result.
// Depends on tfn_pkg. Accepts one vector per cycle.
module tfn_unit3 #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 1
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    input  logic [2:0][IN_W-1:0]                   vec,
    input  logic [SIDE_W-1:0]                      side_in,
    output logic                                   out_valid,
    output logic [2:0][tfn_pkg::UNIT_WIDTH-1:0]    unit_vec,
    output logic [SIDE_W-1:0]                      side_out
);

    localparam int FB     = tfn_pkg::FRAC_BITS;
    localparam int UW     = tfn_pkg::UNIT_WIDTH;
    localparam int MG_W   = FB;
    localparam int SQ_W   = 2 * MG_W;
    localparam int S_W    = SQ_W + 2;
    localparam int ROOT_W = S_W / 2;
    localparam int SQ_N   = ROOT_W;
    localparam int REM_W  = ROOT_W + 3;
    localparam int DV_N   = FB + 1;
    localparam int DREM_W = ROOT_W;
    localparam int PW     = $clog2(IN_W);

    typedef struct packed {
        logic [2:0][MG_W-1:0] mg;
        logic [2:0]           sgn;
        logic                 zero;
        logic [SIDE_W-1:0]    side;
    } carry_t;

    // stage A: magnitudes
    logic                   a_vld_reg;
    logic [2:0][IN_W-1:0]   a_mag_reg, a_mag_next;
    logic [2:0]             a_sgn_reg;
    logic [SIDE_W-1:0]      a_side_reg;
    // stage B: largest magnitude
    logic                   b_vld_reg;
    logic [2:0][IN_W-1:0]   b_mag_reg;
    logic [IN_W-1:0]        b_m_reg, b_m_next;
    logic [2:0]             b_sgn_reg;
    logic [SIDE_W-1:0]      b_side_reg;
    // stage C: leading one position
    logic                   c_vld_reg;
    logic [2:0][IN_W-1:0]   c_mag_reg;
    logic [PW-1:0]          c_p_reg, c_p_next;
    logic                   c_zero_reg;
    logic [2:0]             c_sgn_reg;
    logic [SIDE_W-1:0]      c_side_reg;
    // stage D: normalize, stage E: squares
    logic                   d_vld_reg, e_vld_reg;
    carry_t                 d_c_reg, e_c_reg, d_c_next;
    logic [PW:0]            d_sh;
    logic [IN_W+FB-1:0]     d_wide [3];
    logic [2:0][SQ_W-1:0]   e_sq_reg;
    // square root, one result bit per stage
    logic                   sq_vld_reg  [SQ_N+1];
    carry_t                 sq_c_reg    [SQ_N+1];
    logic [S_W-1:0]         sq_s_reg    [SQ_N+1];
    logic [REM_W-1:0]       sq_rem_reg  [SQ_N+1];
    logic [ROOT_W-1:0]      sq_root_reg [SQ_N+1];
    logic [REM_W-1:0]       sq_rt [SQ_N];
    logic [REM_W-1:0]       sq_tr [SQ_N];
    logic [REM_W-1:0]       sq_rem_next  [SQ_N];
    logic [ROOT_W-1:0]      sq_root_next [SQ_N];
    // restoring divide, one quotient bit per stage
    logic                   dv_vld_reg  [DV_N+1];
    logic [2:0][DREM_W-1:0] dv_rem_reg  [DV_N+1];
    logic [2:0][DV_N-1:0]   dv_q_reg    [DV_N+1];
    logic [ROOT_W-1:0]      dv_len_reg  [DV_N+1];
    logic [2:0]             dv_sgn_reg  [DV_N+1];
    logic                   dv_zero_reg [DV_N+1];
    logic [SIDE_W-1:0]      dv_side_reg [DV_N+1];
    logic [2:0]             dv_mg0_reg;
    logic [DV_N-1:0]        dv_lo [DV_N][3];
    logic [DREM_W:0]        dv_rt [DV_N][3];
    logic                   dv_ge [DV_N][3];
    logic [2:0][DREM_W-1:0] dv_rem_next [DV_N];
    logic [2:0][DV_N-1:0]   dv_q_next   [DV_N];
    // output
    logic                   o_vld_reg;
    logic [2:0][UW-1:0]     o_vec_reg, o_vec_next;
    logic [SIDE_W-1:0]      o_side_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            a_mag_next[i] = vec[i][IN_W-1] ? (~vec[i] + IN_W'(1)) : vec[i];
        end
        b_m_next = a_mag_reg[0];
        if (a_mag_reg[1] > b_m_next)
        begin
            b_m_next = a_mag_reg[1];
        end
        if (a_mag_reg[2] > b_m_next)
        begin
            b_m_next = a_mag_reg[2];
        end
        c_p_next = '0;
        for (int j = 0; j < IN_W; j++)
        begin
            if (b_m_reg[j])
            begin
                c_p_next = PW'(j);
            end
        end
        // top bit of the largest magnitude lands at bit MG_W-1
        d_sh = {1'b0, c_p_reg} + (PW+1)'(1);
        for (int i = 0; i < 3; i++)
        begin
            d_wide[i]      = {c_mag_reg[i], FB'(0)} >> d_sh;
            d_c_next.mg[i] = d_wide[i][MG_W-1:0];
        end
        d_c_next.sgn  = c_sgn_reg;
        d_c_next.zero = c_zero_reg;
        d_c_next.side = c_side_reg;

        for (int k = 0; k < SQ_N; k++)
        begin
            sq_rt[k] = {sq_rem_reg[k][REM_W-3:0], sq_s_reg[k][S_W-1-2*k -: 2]};
            sq_tr[k] = {1'b0, sq_root_reg[k], 2'b01};
            if (sq_rt[k] >= sq_tr[k])
            begin
                sq_rem_next[k]  = sq_rt[k] - sq_tr[k];
                sq_root_next[k] = {sq_root_reg[k][ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = sq_rt[k];
                sq_root_next[k] = {sq_root_reg[k][ROOT_W-2:0], 1'b0};
            end
        end

        // numerator is {mg, len >> 1}; low bits are fed in one per stage
        for (int k = 0; k < DV_N; k++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                dv_lo[k][i] = {dv_mg0_reg[i], dv_len_reg[k][ROOT_W-1:1]};
                dv_rt[k][i] = {dv_rem_reg[k][i], dv_lo[k][i][DV_N-1-k]};
                dv_ge[k][i] = dv_rt[k][i] >= {1'b0, dv_len_reg[k]};
                dv_rem_next[k][i] = dv_ge[k][i]
                    ? DREM_W'(dv_rt[k][i] - {1'b0, dv_len_reg[k]})
                    : DREM_W'(dv_rt[k][i]);
                dv_q_next[k][i] = {dv_q_reg[k][i][DV_N-2:0], dv_ge[k][i]};
            end
        end

        for (int i = 0; i < 3; i++)
        begin
            if (dv_zero_reg[DV_N])
            begin
                o_vec_next[i] = '0;
            end
            else if (dv_sgn_reg[DV_N][i])
            begin
                o_vec_next[i] = UW'(0) - {1'b0, dv_q_reg[DV_N][i]};
            end
            else
            begin
                o_vec_next[i] = {1'b0, dv_q_reg[DV_N][i]};
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            for (int k = 0; k <= SQ_N; k++)
            begin
                sq_vld_reg[k] <= 1'b0;
            end
            for (int k = 0; k <= DV_N; k++)
            begin
                dv_vld_reg[k] <= 1'b0;
            end
            o_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg     <= in_valid;
            b_vld_reg     <= a_vld_reg;
            c_vld_reg     <= b_vld_reg;
            d_vld_reg     <= c_vld_reg;
            e_vld_reg     <= d_vld_reg;
            sq_vld_reg[0] <= e_vld_reg;
            for (int k = 0; k < SQ_N; k++)
            begin
                sq_vld_reg[k+1] <= sq_vld_reg[k];
            end
            dv_vld_reg[0] <= sq_vld_reg[SQ_N];
            for (int k = 0; k < DV_N; k++)
            begin
                dv_vld_reg[k+1] <= dv_vld_reg[k];
            end
            o_vld_reg <= dv_vld_reg[DV_N];
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        a_mag_reg  <= a_mag_next;
        for (int i = 0; i < 3; i++)
        begin
            a_sgn_reg[i] <= vec[i][IN_W-1];
        end
        a_side_reg <= side_in;

        b_mag_reg  <= a_mag_reg;
        b_m_reg    <= b_m_next;
        b_sgn_reg  <= a_sgn_reg;
        b_side_reg <= a_side_reg;

        c_mag_reg  <= b_mag_reg;
        c_p_reg    <= c_p_next;
        c_zero_reg <= (b_m_reg == '0);
        c_sgn_reg  <= b_sgn_reg;
        c_side_reg <= b_side_reg;

        d_c_reg <= d_c_next;

        e_c_reg <= d_c_reg;
        for (int i = 0; i < 3; i++)
        begin
            e_sq_reg[i] <= SQ_W'(d_c_reg.mg[i]) * SQ_W'(d_c_reg.mg[i]);
        end

        sq_c_reg[0]    <= e_c_reg;
        sq_s_reg[0]    <= S_W'(e_sq_reg[0]) + S_W'(e_sq_reg[1]) + S_W'(e_sq_reg[2]);
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
        for (int k = 0; k < SQ_N; k++)
        begin
            sq_c_reg[k+1]    <= sq_c_reg[k];
            sq_s_reg[k+1]    <= sq_s_reg[k];
            sq_rem_reg[k+1]  <= sq_rem_next[k];
            sq_root_reg[k+1] <= sq_root_next[k];
        end

        for (int i = 0; i < 3; i++)
        begin
            dv_rem_reg[0][i] <= DREM_W'(sq_c_reg[SQ_N].mg[i] >> 1);
            dv_mg0_reg[i]    <= sq_c_reg[SQ_N].mg[i][0];
        end
        dv_q_reg[0]    <= '0;
        dv_len_reg[0]  <= sq_root_reg[SQ_N];
        dv_sgn_reg[0]  <= sq_c_reg[SQ_N].sgn;
        dv_zero_reg[0] <= sq_c_reg[SQ_N].zero;
        dv_side_reg[0] <= sq_c_reg[SQ_N].side;
        for (int k = 0; k < DV_N; k++)
        begin
            dv_rem_reg[k+1]  <= dv_rem_next[k];
            dv_q_reg[k+1]    <= dv_q_next[k];
            dv_len_reg[k+1]  <= dv_len_reg[k];
            dv_sgn_reg[k+1]  <= dv_sgn_reg[k];
            dv_zero_reg[k+1] <= dv_zero_reg[k];
            dv_side_reg[k+1] <= dv_side_reg[k];
        end

        o_vec_reg  <= o_vec_next;
        o_side_reg <= dv_side_reg[DV_N];
    end

    assign out_valid = o_vld_reg;
    assign unit_vec  = o_vec_reg;
    assign side_out  = o_side_reg;

endmodule

>>> hdl/triangle_face_normal.sv
// Triangle face normal: each accepted start transfer yields a done strobe.
// Throughput one triangle per cycle; busy is never raised, the pipeline never stalls.
// The path runs through two chained unit-vector pipelines (square root and divide,
// one result bit per stage). rst_n clears all valid bits and restores
// min_cross_length to its reset value; payload registers are not reset.
module triangle_face_normal (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  tfn_pkg::tfn_in_t                   vertices,
    output logic                               done,
    output tfn_pkg::tfn_out_t                  result,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tfn_pkg::CFG_WIDTH-1:0]      cfg_data
);

    localparam int CW      = tfn_pkg::COORD_WIDTH;
    localparam int DW      = CW + 1;          // edge difference width
    localparam int UW      = tfn_pkg::UNIT_WIDTH;
    localparam int FB      = tfn_pkg::FRAC_BITS;
    localparam int PROD_W  = 2 * UW;          // Q2.60 products
    localparam int N_W     = PROD_W - 1;      // cross components fit in 63 bits
    localparam int R_W     = UW;              // cross rounded to Q1.30
    localparam int THR_W   = 2 * tfn_pkg::CFG_WIDTH;
    localparam int LATENCY = 147;
    localparam logic [THR_W-1:0] THR_SQ_RESET =
        THR_W'(tfn_pkg::MIN_CROSS_RESET) * THR_W'(tfn_pkg::MIN_CROSS_RESET);

    // Threshold register; its square is what the test compares against.
    logic [tfn_pkg::CFG_WIDTH-1:0] min_cross_length_reg;
    logic [THR_W-1:0]              thr_sq_reg;

    // Edge differences: b-a, c-a, c-b.
    logic                    d_vld_reg;
    logic [2:0][DW-1:0]      d_ba_reg, d_ca_reg, d_cb_reg;

    // Edge unit vectors.
    logic                    e_vld, e_vld_ca, e_vld_cb;
    logic [2:0][UW-1:0]      u_ba, u_ca, u_cb;
    logic signed [UW-1:0]    v [3];
    logic signed [UW-1:0]    w1 [3];
    logic signed [UW-1:0]    w2 [3];

    // Cross product and threshold test, stages X1..X5.
    logic                    x1_vld_reg, x2_vld_reg, x3_vld_reg, x4_vld_reg, x5_vld_reg;
    logic signed [PROD_W-1:0] x1_p1_reg [6];
    logic signed [PROD_W-1:0] x1_p2_reg [6];
    logic signed [PROD_W-1:0] x1_p1_next [6];
    logic signed [PROD_W-1:0] x1_p2_next [6];
    logic [2:0][N_W-1:0]     x2_n1_reg, x2_n2_reg, x3_n1_reg, x3_n2_reg;
    logic [2:0][N_W-1:0]     x4_n1_reg, x4_n2_reg;
    logic [2:0][N_W-1:0]     x2_n1_next, x2_n2_next;
    logic [2:0][N_W-1:0]     x3_m1, x3_m2;
    logic [2:0][R_W-1:0]     x3_r1_reg, x3_r2_reg, x3_r1_next, x3_r2_next;
    logic [2:0][PROD_W-1:0]  x4_s1_reg, x4_s2_reg;
    logic [PROD_W-1:0]       x5_sum1, x5_sum2;
    logic                    x5_short1, x5_short2;
    logic [2:0][N_W-1:0]     x5_n_reg;
    logic [1:0]              x5_flags_reg;   // {used_alternate, degenerate}

    // Final normalization.
    logic                    n_vld;
    logic [2:0][UW-1:0]      n_unit;
    logic [1:0]              n_flags;
    logic                    n_zero;

    logic                    done_reg;
    tfn_pkg::tfn_out_t       result_reg;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_cross_length_reg <= tfn_pkg::MIN_CROSS_RESET;
            thr_sq_reg           <= THR_SQ_RESET;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                min_cross_length_reg <= cfg_data;
            end
            thr_sq_reg <= THR_W'(min_cross_length_reg) * THR_W'(min_cross_length_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        d_ba_reg[0] <= DW'(vertices.b_x) - DW'(vertices.a_x);
        d_ba_reg[1] <= DW'(vertices.b_y) - DW'(vertices.a_y);
        d_ba_reg[2] <= DW'(vertices.b_z) - DW'(vertices.a_z);
        d_ca_reg[0] <= DW'(vertices.c_x) - DW'(vertices.a_x);
        d_ca_reg[1] <= DW'(vertices.c_y) - DW'(vertices.a_y);
        d_ca_reg[2] <= DW'(vertices.c_z) - DW'(vertices.a_z);
        d_cb_reg[0] <= DW'(vertices.c_x) - DW'(vertices.b_x);
        d_cb_reg[1] <= DW'(vertices.c_y) - DW'(vertices.b_y);
        d_cb_reg[2] <= DW'(vertices.c_z) - DW'(vertices.b_z);
    end

    // The edges b-a, c-a and c-b are normalized in parallel; the fallback edge is
    // ready by the time the first cross product is tested.
    tfn_unit3 #(.IN_W(DW), .SIDE_W(1)) u_edge_ba (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .vec       (d_ba_reg),
        .side_in   (1'b0),
        .out_valid (e_vld),
        .unit_vec  (u_ba),
        .side_out  ()
    );

    tfn_unit3 #(.IN_W(DW), .SIDE_W(1)) u_edge_ca (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .vec       (d_ca_reg),
        .side_in   (1'b0),
        .out_valid (e_vld_ca),
        .unit_vec  (u_ca),
        .side_out  ()
    );

    tfn_unit3 #(.IN_W(DW), .SIDE_W(1)) u_edge_cb (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (d_vld_reg),
        .vec       (d_cb_reg),
        .side_in   (1'b0),
        .out_valid (e_vld_cb),
        .unit_vec  (u_cb),
        .side_out  ()
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v[i]  = u_ba[i];
            w1[i] = u_ca[i];
            w2[i] = u_cb[i];
        end
        // X1: exact Q2.60 products for V x W1 and V x W2
        x1_p1_next[0] = v[1] * w1[2];
        x1_p1_next[1] = v[2] * w1[1];
        x1_p1_next[2] = v[2] * w1[0];
        x1_p1_next[3] = v[0] * w1[2];
        x1_p1_next[4] = v[0] * w1[1];
        x1_p1_next[5] = v[1] * w1[0];
        x1_p2_next[0] = v[1] * w2[2];
        x1_p2_next[1] = v[2] * w2[1];
        x1_p2_next[2] = v[2] * w2[0];
        x1_p2_next[3] = v[0] * w2[2];
        x1_p2_next[4] = v[0] * w2[1];
        x1_p2_next[5] = v[1] * w2[0];
        // X2: differences
        for (int i = 0; i < 3; i++)
        begin
            x2_n1_next[i] = N_W'(x1_p1_reg[2*i] - x1_p1_reg[2*i+1]);
            x2_n2_next[i] = N_W'(x1_p2_reg[2*i] - x1_p2_reg[2*i+1]);
        end
        // X3: magnitude rounded to Q1.30, tie away from zero
        for (int i = 0; i < 3; i++)
        begin
            x3_m1[i] = x2_n1_reg[i][N_W-1] ? (N_W'(0) - x2_n1_reg[i]) : x2_n1_reg[i];
            x3_m2[i] = x2_n2_reg[i][N_W-1] ? (N_W'(0) - x2_n2_reg[i]) : x2_n2_reg[i];
            x3_r1_next[i] = R_W'((PROD_W'(x3_m1[i]) + (PROD_W'(1) << (FB - 1))) >> FB);
            x3_r2_next[i] = R_W'((PROD_W'(x3_m2[i]) + (PROD_W'(1) << (FB - 1))) >> FB);
        end
        // X5: sum of squares against threshold squared
        x5_sum1   = x4_s1_reg[0] + x4_s1_reg[1] + x4_s1_reg[2];
        x5_sum2   = x4_s2_reg[0] + x4_s2_reg[1] + x4_s2_reg[2];
        x5_short1 = x5_sum1 < PROD_W'(thr_sq_reg);
        x5_short2 = x5_sum2 < PROD_W'(thr_sq_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_vld_reg  <= 1'b0;
            x1_vld_reg <= 1'b0;
            x2_vld_reg <= 1'b0;
            x3_vld_reg <= 1'b0;
            x4_vld_reg <= 1'b0;
            x5_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            d_vld_reg  <= start && !busy;
            x1_vld_reg <= e_vld;
            x2_vld_reg <= x1_vld_reg;
            x3_vld_reg <= x2_vld_reg;
            x4_vld_reg <= x3_vld_reg;
            x5_vld_reg <= x4_vld_reg;
            done_reg   <= n_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        x1_p1_reg <= x1_p1_next;
        x1_p2_reg <= x1_p2_next;
        x2_n1_reg <= x2_n1_next;
        x2_n2_reg <= x2_n2_next;
        x3_n1_reg <= x2_n1_reg;
        x3_n2_reg <= x2_n2_reg;
        x3_r1_reg <= x3_r1_next;
        x3_r2_reg <= x3_r2_next;
        x4_n1_reg <= x3_n1_reg;
        x4_n2_reg <= x3_n2_reg;
        for (int i = 0; i < 3; i++)
        begin
            x4_s1_reg[i] <= PROD_W'(x3_r1_reg[i]) * PROD_W'(x3_r1_reg[i]);
            x4_s2_reg[i] <= PROD_W'(x3_r2_reg[i]) * PROD_W'(x3_r2_reg[i]);
        end
        // fall back to edge c-b when the first normal is too short
        x5_n_reg     <= x5_short1 ? x4_n2_reg : x4_n1_reg;
        x5_flags_reg <= {x5_short1, x5_short1 ? x5_short2 : 1'b0};
    end

    tfn_unit3 #(.IN_W(N_W), .SIDE_W(2)) u_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (x5_vld_reg),
        .vec       (x5_n_reg),
        .side_in   (x5_flags_reg),
        .out_valid (n_vld),
        .unit_vec  (n_unit),
        .side_out  (n_flags)
    );

    assign n_zero = (n_unit[0] == '0) && (n_unit[1] == '0) && (n_unit[2] == '0);

    always_ff @(posedge clk)
    begin
        result_reg.normal_x       <= n_unit[0];
        result_reg.normal_y       <= n_unit[1];
        result_reg.normal_z       <= n_unit[2];
        result_reg.used_alternate <= n_flags[1];
        result_reg.degenerate     <= n_flags[0] || n_zero;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // Every accepted triangle yields its result a fixed time later.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##LATENCY done)
        else $error("result strobe missing after accepted triangle");

    // The edge pipelines for b-a, c-a and c-b stay in lockstep.
    a_edge_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        e_vld == e_vld_ca && e_vld == e_vld_cb)
        else $error("edge unit pipelines out of step");

    a_zero_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0
        |-> result.degenerate)
        else $error("zero normal not flagged degenerate");

    // Without the fallback, degenerate can only come from a zero normal.
    a_primary_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
        done && !result.used_alternate && result.degenerate
        |-> result.normal_x == 0 && result.normal_y == 0 && result.normal_z == 0)
        else $error("degenerate set on primary edge pair");

    a_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> result.normal_x <= 32'sd1073741824 && result.normal_x >= -32'sd1073741824
              && result.normal_y <= 32'sd1073741824 && result.normal_y >= -32'sd1073741824
              && result.normal_z <= 32'sd1073741824 && result.normal_z >= -32'sd1073741824)
        else $error("normal component outside Q1.30 unit range");

endmodule
